>>> hw/rtl/wncs_pkg.sv
package wncs_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int VAL_W   = 15;
  localparam int WT_W    = 10;
  localparam int ENTRY_W = 2 * VAL_W + WT_W;
  localparam int SQ_W    = 2 * VAL_W;
  localparam int D2_W    = SQ_W + 1;
  localparam int W2_W    = 2 * WT_W;
  localparam int PROD_W  = D2_W + W2_W;

  // stages from scan issue to the best-entry update
  localparam int PIPE_LAT = 5;
  localparam int DRAIN_W  = 3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic start;
    logic wr_entry;
    logic issue;
    logic load_out;
  } wncs_cmd_t;

endpackage

>>> hw/rtl/weighted_nearest_class_select_unit.sv
// Write transaction: accepted while idle, the next transaction can follow at once.
// Query transaction: scans n = min(entry_count, table depth) entries and drains the
// pipeline; n = 0 skips both. Queries run one at a time, one table entry per cycle
// through the entry memory read port and a five-stage distance and compare pipeline.
// Reset (rst_n, synchronous, active low) clears the valid marks, entry_count and all
// control state; stored temperature, moisture and weight are not cleared.
module weighted_nearest_class_select_unit #(
  parameter int MAX_ENTRIES = wncs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [wncs_pkg::IDX_W-1:0]  in_entry_index,
  input  logic                        in_entry_valid,
  input  logic [wncs_pkg::VAL_W-1:0]  in_entry_temperature,
  input  logic [wncs_pkg::VAL_W-1:0]  in_entry_moisture,
  input  logic [wncs_pkg::WT_W-1:0]   in_entry_weight,
  input  logic [wncs_pkg::VAL_W-1:0]  in_query_temperature,
  input  logic [wncs_pkg::VAL_W-1:0]  in_query_moisture,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wncs_pkg::IDX_W-1:0]  out_best_index,
  output logic                        out_found,
  input  logic                        cfg_wr_en,
  input  logic [wncs_pkg::CNT_W-1:0]  cfg_wr_data
);
  import wncs_pkg::*;

  localparam int DEPTH = (MAX_ENTRIES < (1 << IDX_W)) ? MAX_ENTRIES : (1 << IDX_W);
  localparam int IW    = $clog2(DEPTH);

  wncs_cmd_t     cmd;
  logic [IW-1:0] scan_addr;

  wncs_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .scan_addr   (scan_addr)
  );

  wncs_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .scan_addr            (scan_addr),
    .in_entry_index       (in_entry_index),
    .in_entry_valid       (in_entry_valid),
    .in_entry_temperature (in_entry_temperature),
    .in_entry_moisture    (in_entry_moisture),
    .in_entry_weight      (in_entry_weight),
    .in_query_temperature (in_query_temperature),
    .in_query_moisture    (in_query_moisture),
    .out_best_index       (out_best_index),
    .out_found            (out_found)
  );

`ifndef SYNTHESIS
  a_empty_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_best_index == '0)
    else $error("result without a chosen entry carries a nonzero index");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !in_ready)
    else $error("input ready while the table scan is running");

  a_query_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_ready)
    else $error("input ready in the cycle after a query was accepted");
`endif

endmodule

>>> hw/rtl/wncs_ctrl.sv
module wncs_ctrl #(
  parameter int MAX_ENTRIES = wncs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_req_type,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  input  logic                                   cfg_wr_en,
  input  logic [wncs_pkg::CNT_W-1:0]             cfg_wr_data,
  output wncs_pkg::wncs_cmd_t                    cmd,
  output logic [$clog2((MAX_ENTRIES < (1 << wncs_pkg::IDX_W)) ?
                MAX_ENTRIES : (1 << wncs_pkg::IDX_W))-1:0] scan_addr
);
  import wncs_pkg::*;

  localparam int DEPTH = (MAX_ENTRIES < (1 << IDX_W)) ? MAX_ENTRIES : (1 << IDX_W);
  localparam int IW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DRAIN_W-1:0] drain_r;
  logic               out_valid_r;
  logic [CNT_W-1:0]   n_clamp;
  logic               accept;

  always_comb begin
    accept       = in_valid && (state_r == ST_IDLE);
    n_clamp      = (count_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : count_r;
    cmd.wr_entry = accept && (in_req_type == REQ_WRITE);
    cmd.start    = accept && (in_req_type == REQ_QUERY);
    cmd.issue    = (state_r == ST_SCAN);
    cmd.load_out = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign scan_addr = cnt_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      n_r         <= '0;
      cnt_r       <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.start) begin
            n_r     <= n_clamp;
            cnt_r   <= '0;
            state_r <= (n_clamp == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if ((cnt_r + CNT_W'(1)) == n_r) begin
            drain_r <= DRAIN_W'(PIPE_LAT - 1);
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_r == '0) begin
            state_r <= ST_FINISH;
          end else begin
            drain_r <= drain_r - DRAIN_W'(1);
          end
        end
        ST_FINISH: begin
          if (cmd.load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/wncs_datapath.sv
module wncs_datapath #(
  parameter int MAX_ENTRIES = wncs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  wncs_pkg::wncs_cmd_t                    cmd,
  input  logic [$clog2((MAX_ENTRIES < (1 << wncs_pkg::IDX_W)) ?
                MAX_ENTRIES : (1 << wncs_pkg::IDX_W))-1:0] scan_addr,
  input  logic [wncs_pkg::IDX_W-1:0]             in_entry_index,
  input  logic                                   in_entry_valid,
  input  logic [wncs_pkg::VAL_W-1:0]             in_entry_temperature,
  input  logic [wncs_pkg::VAL_W-1:0]             in_entry_moisture,
  input  logic [wncs_pkg::WT_W-1:0]              in_entry_weight,
  input  logic [wncs_pkg::VAL_W-1:0]             in_query_temperature,
  input  logic [wncs_pkg::VAL_W-1:0]             in_query_moisture,
  output logic [wncs_pkg::IDX_W-1:0]             out_best_index,
  output logic                                   out_found
);
  import wncs_pkg::*;

  localparam int DEPTH = (MAX_ENTRIES < (1 << IDX_W)) ? MAX_ENTRIES : (1 << IDX_W);
  localparam int IW    = $clog2(DEPTH);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vbits_r;
  logic               wr_ok;

  logic [VAL_W-1:0]   q_temp_r;
  logic [VAL_W-1:0]   q_moist_r;

  logic [ENTRY_W-1:0] s1_word_r;
  logic               s1_vld_r;
  logic [IW-1:0]      s1_idx_r;
  logic [VAL_W-1:0]   s1_temp;
  logic [VAL_W-1:0]   s1_moist;
  logic [WT_W-1:0]    s1_wt;

  logic [VAL_W-1:0]   s2_dt_r;
  logic [VAL_W-1:0]   s2_dm_r;
  logic [WT_W-1:0]    s2_w_r;
  logic               s2_vld_r;
  logic [IW-1:0]      s2_idx_r;

  logic [SQ_W-1:0]    s3_dt2_r;
  logic [SQ_W-1:0]    s3_dm2_r;
  logic [W2_W-1:0]    s3_w2_r;
  logic               s3_vld_r;
  logic [IW-1:0]      s3_idx_r;

  logic [D2_W-1:0]    s4_d2_r;
  logic [W2_W-1:0]    s4_w2_r;
  logic               s4_vld_r;
  logic [IW-1:0]      s4_idx_r;

  logic [D2_W-1:0]    s5_d2_r;
  logic [W2_W-1:0]    s5_w2_r;
  logic               s5_vld_r;
  logic [IW-1:0]      s5_idx_r;
  logic [PROD_W-1:0]  s5_pk_cand_r;
  logic [PROD_W-1:0]  s5_pk_best_r;
  logic [PROD_W-1:0]  s5_pb_cand_r;
  logic [PROD_W-1:0]  s5_pb_best_r;

  logic [D2_W-1:0]    best_d2_r;
  logic [W2_W-1:0]    best_w2_r;
  logic [IW-1:0]      best_idx_r;
  logic               have_r;
  logic               won_r;
  logic               won;

  logic [IDX_W-1:0]   out_best_index_r;
  logic               out_found_r;

  assign wr_ok = cmd.wr_entry && ({26'd0, in_entry_index} < 32'(DEPTH));

  assign s1_temp  = s1_word_r[ENTRY_W-1 -: VAL_W];
  assign s1_moist = s1_word_r[WT_W +: VAL_W];
  assign s1_wt    = s1_word_r[WT_W-1:0];

  // compare against the previous candidate when it just took the lead
  always_comb begin
    won = s5_vld_r && (won_r ? (s5_pk_cand_r < s5_pk_best_r)
                             : (!have_r || (s5_pb_cand_r < s5_pb_best_r)));
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[in_entry_index[IW-1:0]] <= {in_entry_temperature, in_entry_moisture,
                                      in_entry_weight};
    end
    s1_word_r <= mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbits_r  <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      have_r   <= 1'b0;
      won_r    <= 1'b0;
    end else begin
      if (wr_ok) begin
        vbits_r[in_entry_index[IW-1:0]] <= in_entry_valid;
      end
      s1_vld_r <= cmd.issue && vbits_r[scan_addr];
      s2_vld_r <= s1_vld_r && (s1_wt != '0);
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      if (cmd.start) begin
        have_r <= 1'b0;
        won_r  <= 1'b0;
      end else begin
        won_r <= won;
        if (won) begin
          have_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_temp_r  <= in_query_temperature;
      q_moist_r <= in_query_moisture;
    end
    s1_idx_r <= scan_addr;

    s2_dt_r  <= (q_temp_r >= s1_temp) ? (q_temp_r - s1_temp) : (s1_temp - q_temp_r);
    s2_dm_r  <= (q_moist_r >= s1_moist) ? (q_moist_r - s1_moist) : (s1_moist - q_moist_r);
    s2_w_r   <= s1_wt;
    s2_idx_r <= s1_idx_r;

    s3_dt2_r <= SQ_W'(s2_dt_r) * SQ_W'(s2_dt_r);
    s3_dm2_r <= SQ_W'(s2_dm_r) * SQ_W'(s2_dm_r);
    s3_w2_r  <= W2_W'(s2_w_r) * W2_W'(s2_w_r);
    s3_idx_r <= s2_idx_r;

    s4_d2_r  <= D2_W'(s3_dt2_r) + D2_W'(s3_dm2_r);
    s4_w2_r  <= s3_w2_r;
    s4_idx_r <= s3_idx_r;

    s5_d2_r      <= s4_d2_r;
    s5_w2_r      <= s4_w2_r;
    s5_idx_r     <= s4_idx_r;
    s5_pk_cand_r <= PROD_W'(s4_d2_r) * PROD_W'(s5_w2_r);
    s5_pk_best_r <= PROD_W'(s5_d2_r) * PROD_W'(s4_w2_r);
    s5_pb_cand_r <= PROD_W'(s4_d2_r) * PROD_W'(best_w2_r);
    s5_pb_best_r <= PROD_W'(best_d2_r) * PROD_W'(s4_w2_r);

    if (won) begin
      best_d2_r  <= s5_d2_r;
      best_w2_r  <= s5_w2_r;
      best_idx_r <= s5_idx_r;
    end

    if (cmd.load_out) begin
      out_best_index_r <= have_r ? IDX_W'(best_idx_r) : '0;
      out_found_r      <= have_r;
    end
  end

  assign out_best_index = out_best_index_r;
  assign out_found      = out_found_r;

endmodule
